/* hw/rtl/lkv_pkg.sv */
// lkv_pkg: shared constants and types for the LRU key/value cache.
// Used by lkv_cell, lru_key_value_cache and lkv_checker; depends on nothing.
package lkv_pkg;

   localparam int CAPACITY = 20;                      // number of cells
   localparam int KEY_W    = 64;                      // bits of the key that match
   localparam int VAL_W    = 31;                      // stored identifier bits
   localparam int OCC_W    = $clog2(CAPACITY + 1);    // fill count width

   // found value reported on a miss
   localparam logic signed [31:0] MISS_ID = -32'sd1;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [VAL_W-1:0] val_type;
   typedef logic [OCC_W-1:0] occ_type;

   // Per-cell control, driven by the top level
   typedef struct packed {
      logic compare;    // latch the key match this cycle
      logic valid;      // cell holds a live entry and the request takes part in search
      logic load;       // this cell is the tail slot: take the request key and tail value
      logic shift;      // shift cells at/above the removal point down by one
      logic shift_all;  // removal point is cell 0 (eviction of the oldest entry)
   } cell_ctrl_type;

endpackage

/* hw/rtl/lkv_cell.sv */
// lkv_cell: one entry of the recency-ordered chain (key, identifier, match flag).
// Depends on lkv_pkg.
module lkv_cell (
   input  logic                  clock,
   input  lkv_pkg::cell_ctrl_type ctrl,
   input  lkv_pkg::key_type      req_key,
   input  lkv_pkg::val_type      tail_val,
   input  lkv_pkg::key_type      nbr_key,
   input  lkv_pkg::val_type      nbr_val,
   input  logic                  seen_in,
   input  lkv_pkg::val_type      found_in,
   output logic                  seen_out,
   output lkv_pkg::val_type      found_out,
   output lkv_pkg::key_type      key_out,
   output lkv_pkg::val_type      val_out
);

   lkv_pkg::key_type key_ff;
   lkv_pkg::val_type val_ff;
   logic             match_ff;
   logic             first;

   // oldest match wins: a match below this cell masks ours
   assign first     = match_ff & ~seen_in;
   assign seen_out  = seen_in | match_ff;
   assign found_out = found_in | (first ? val_ff : '0);
   assign key_out   = key_ff;
   assign val_out   = val_ff;

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         match_ff <= ctrl.valid && (key_ff == req_key);
      end
      if (ctrl.load) begin
         key_ff <= req_key;
         val_ff <= tail_val;
      end else if (ctrl.shift && (seen_out || ctrl.shift_all)) begin
         key_ff <= nbr_key;
         val_ff <= nbr_val;
      end
   end

endmodule

/* hw/rtl/lru_key_value_cache.sv */
// lru_key_value_cache: top level, request sequencer and chain of lkv_cell entries.
// Depends on lkv_pkg and lkv_cell.
//
// Usage
//   Request channel: drive req_op/req_key/req_value with start; the word is
//   taken at a rising edge where start is high and busy is low. req_op = 0
//   looks the key up, req_op = 1 inserts it with req_value (negative value:
//   insert ignored, result is a miss, nothing changes).
//   Response channel: exactly one word per request, shown for one cycle with
//   rsp_valid high. rsp_hit tells whether the key was present; rsp_found_value
//   is the stored identifier on a hit and -1 otherwise. The receiver cannot
//   stall: a word not taken in its cycle is gone.
//   A request first passes a compare cycle, which registers a key match in
//   every cell; the update cycle then runs the oldest-match chain through the
//   cells and updates them (promote, append or evict), and the response
//   register is loaded at its end. The next request is accepted in
//   that update cycle, so busy is high for one cycle after each accept.
//   Reset: synchronous, active high; empties the cache (fill count zero) and
//   drops any request in flight. Cell contents are not cleared; cells above
//   the fill count never take part in a match.
//   Cell 0 holds the oldest entry, cell occupancy-1 the most recent.
module lru_key_value_cache (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [63:0]                 req_key,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic signed [31:0]          rsp_found_value
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CMP,
      PH_UPD
   } phase_type;

   phase_type             phase_ff;
   lkv_pkg::occ_type      occ_ff;
   logic                  req_op_ff;
   lkv_pkg::key_type      req_key_ff;
   logic signed [31:0]    req_value_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic signed [31:0]    rsp_found_value_ff;

   logic                  accept;
   logic                  is_insert;
   logic                  ignore;
   logic                  hit;
   logic                  full;
   logic                  ins_miss;
   logic                  full_ins;
   logic                  upd;
   lkv_pkg::occ_type      tail_idx;
   lkv_pkg::val_type      tail_val;

   logic                  seen   [lkv_pkg::CAPACITY+1];
   lkv_pkg::val_type      found  [lkv_pkg::CAPACITY+1];
   lkv_pkg::key_type      cell_key [lkv_pkg::CAPACITY];
   lkv_pkg::val_type      cell_val [lkv_pkg::CAPACITY];

   assign busy   = (phase_ff == PH_CMP);
   assign accept = start && !busy;
   assign upd    = (phase_ff == PH_UPD);

   // negative insert: no search, no change
   assign is_insert = (req_op_ff == lkv_pkg::OP_INSERT);
   assign ignore    = is_insert && req_value_ff[31];
   assign hit       = seen[lkv_pkg::CAPACITY];
   assign full      = (occ_ff == lkv_pkg::OCC_W'(lkv_pkg::CAPACITY));
   assign ins_miss  = is_insert && !ignore && !hit;
   assign full_ins  = ins_miss && full;

   // tail slot: last live cell on promote or eviction, next free cell on append
   assign tail_idx = (hit || full) ? occ_ff - 1'b1 : occ_ff;
   assign tail_val = hit ? found[lkv_pkg::CAPACITY] : req_value_ff[lkv_pkg::VAL_W-1:0];

   assign seen[0]  = 1'b0;
   assign found[0] = '0;

   for (genvar i = 0; i < lkv_pkg::CAPACITY; i++) begin : g_cell
      lkv_pkg::cell_ctrl_type ctrl;
      lkv_pkg::key_type       nbr_key;
      lkv_pkg::val_type       nbr_val;

      assign ctrl.compare   = (phase_ff == PH_CMP);
      assign ctrl.valid     = (occ_ff > lkv_pkg::OCC_W'(i)) && !ignore;
      assign ctrl.load      = upd && (hit || ins_miss) && (tail_idx == lkv_pkg::OCC_W'(i));
      assign ctrl.shift     = upd && (hit || full_ins);
      assign ctrl.shift_all = full_ins;

      if (i == lkv_pkg::CAPACITY - 1) begin : g_last
         assign nbr_key = req_key_ff;
         assign nbr_val = tail_val;
      end else begin : g_mid
         assign nbr_key = cell_key[i+1];
         assign nbr_val = cell_val[i+1];
      end

      lkv_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .req_key   (req_key_ff),
         .tail_val  (tail_val),
         .nbr_key   (nbr_key),
         .nbr_val   (nbr_val),
         .seen_in   (seen[i]),
         .found_in  (found[i]),
         .seen_out  (seen[i+1]),
         .found_out (found[i+1]),
         .key_out   (cell_key[i]),
         .val_out   (cell_val[i])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_op_ff    <= req_op;
         req_key_ff   <= req_key[lkv_pkg::KEY_W-1:0];
         req_value_ff <= req_value;
      end
      if (upd) begin
         rsp_hit_ff         <= hit;
         rsp_found_value_ff <= hit ? {1'b0, found[lkv_pkg::CAPACITY]} : lkv_pkg::MISS_ID;
      end
      if (reset) begin
         phase_ff     <= PH_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= upd;
         if (upd && ins_miss && !full) begin
            occ_ff <= occ_ff + 1'b1;
         end
         unique case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  phase_ff <= PH_CMP;
               end
            end
            PH_CMP: begin
               phase_ff <= PH_UPD;
            end
            PH_UPD: begin
               phase_ff <= start ? PH_CMP : PH_IDLE;
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_value = rsp_found_value_ff;

endmodule

/* hw/rtl/lkv_checker.sv */
// lkv_checker: port-level assertions for lru_key_value_cache, plus its bind.
// Depends on lkv_pkg and the lru_key_value_cache port list.
module lkv_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_hit,
   input logic signed [31:0] rsp_found_value
);

   // each accepted word gets its response after its compare and update phases
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing after accepted request");

   // busy covers only the compare cycle
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // responses never come in back-to-back cycles
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   // miss returns -1, hit returns a non-negative identifier
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_hit && !rsp_found_value[31]) ||
                     (!rsp_hit && rsp_found_value == lkv_pkg::MISS_ID)))
      else $error("found value inconsistent with hit flag");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_found_value (rsp_found_value)
);
